/* rtl/pawk_pkg.sv */
// Shared types, constants and helpers for the polyline arc-length walker.
// Used by polyline_arc_length_walker; no dependencies.
package pawk_pkg;

    localparam int DIST_W   = 24;
    localparam int PT_W     = 24;
    localparam int SEG_W    = 5;
    localparam int MODE_W   = 3;
    localparam int IN_DW    = 80;
    localparam int OUT_DW   = 104;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_NEW    = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_SETPOS = 3'd2,
        MODE_SKIP   = 3'd3,
        MODE_UNWIND = 3'd4
    } t_mode;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

/* rtl/polyline_arc_length_walker.sv */
// Polyline arc-length walker: holds one polyline in a vertex RAM plus a cursor,
// and moves the cursor along the path. Depends on pawk_pkg and pawk_ram.
//
// One input word is taken at a time; s_axis_tready is high only while idle.
// New path, unused modes and a full-path append go straight to the emit state.
// An append is a RAM read, two squaring passes through the shared multiplier
// and a 25-step square root (two radicand bits a cycle); a coordinate difference
// beyond the distance range saturates the length without them. A move
// (set position, skip, unwind) walks the path one segment at a time: each
// segment's length is found the same way, and the final segment adds two
// interpolations, each one multiply plus a restoring divide of
// max(COORD_WIDTH+1,24)+24 steps. Unwind emits the start point, every passed
// vertex and the final point, the final one with m_axis_tlast set; other modes
// emit one word with tlast set. An unwind with no segment ahead emits nothing.
// The output register is separate: a word may wait there while the next input
// is taken, and the walker stalls only when it must emit again before that word
// has been taken.
module polyline_arc_length_walker
    import pawk_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_WIDTH  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // mode[2:0], vertex_x[26:3], vertex_y[50:27], distance[74:51], zero pad
    input  logic [IN_DW-1:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // point_x[23:0], point_y[47:24], segment[52:48], travelled[76:53],
    // total_length[100:77], at_end[101], zero pad
    output logic [OUT_DW-1:0]  m_axis_tdata,
    output logic               m_axis_tlast
);
    localparam int CW    = COORD_WIDTH;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VCW   = $clog2(MAX_VERTICES + 1);
    localparam int MA    = (CW + 1 > DIST_W) ? CW + 1 : DIST_W;
    localparam int NW    = MA + DIST_W;
    localparam int SQ_W  = 50;
    localparam int RT_W  = SQ_W / 2;
    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RDWAIT, S_RDUSE, S_WALK, S_WSTART, S_NEXT,
        S_SL_DIFF, S_SL_MX, S_SL_MY, S_SQRT, S_SL_SAT, S_SL_DONE,
        S_LMUL, S_DIV, S_LFIN, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RK_APPEND, RK_V0_SET, RK_V0_WALK, RK_NEXT
    } t_rdkind;

    t_state                  r_state;
    t_rdkind                 r_rdk;
    logic                    r_unwind;
    logic signed [CW-1:0]    r_in_x, r_in_y;
    logic [DIST_W-1:0]       r_len;
    // path and cursor
    logic [VCW-1:0]          r_vcnt;
    logic [AW-1:0]           r_seg;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic [DIST_W-1:0]       r_dist;
    logic                    r_end;
    logic [DIST_W-1:0]       r_plen;
    // shared arithmetic
    logic signed [CW-1:0]    r_ax, r_ay, r_bx, r_by;
    logic [MA-1:0]           r_dx, r_dy;
    logic [SQ_W-1:0]         r_acc;
    logic [RT_W-1:0]         r_root;
    logic [RT_W:0]           r_rem;
    logic [DIST_W-1:0]       r_sl;
    logic [NW-1:0]           r_num;
    logic [DIST_W-1:0]       r_drem;
    logic                    r_neg;
    logic                    r_ylane;
    logic [CNT_W-1:0]        r_cnt;
    logic [AW-1:0]           r_raddr;
    // output register
    logic                    r_ovalid;
    logic [OUT_DW-1:0]       r_odata;
    logic                    r_olast;
    logic                    r_elast;

    function automatic logic [MA:0] mag_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
        logic signed [MA:0] d;
        d = (MA+1)'(b) - (MA+1)'(a);
        return d[MA] ? (MA+1)'(-d) : (MA+1)'(d);
    endfunction

    // input field split
    logic [MODE_W-1:0]    in_mode;
    logic signed [CW-1:0] in_x, in_y;
    logic [DIST_W-1:0]    in_dist;
    logic                 in_take;

    assign in_mode = s_axis_tdata[2:0];
    assign in_x    = CW'(signed'(s_axis_tdata[26:3]));
    assign in_y    = CW'(signed'(s_axis_tdata[50:27]));
    assign in_dist = s_axis_tdata[74:51];
    assign in_take = s_axis_tvalid && s_axis_tready;

    // vertex RAM: {y, x}
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [2*CW-1:0]     ram_wdata;
    logic [2*CW-1:0]     ram_rdata;
    logic signed [CW-1:0] rd_x, rd_y;
    logic                new_path;

    assign new_path = in_take && (t_mode'(in_mode) == MODE_NEW
                      || (t_mode'(in_mode) == MODE_APPEND && r_vcnt == '0));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {in_y, in_x};
        if (new_path) begin
            ram_we = 1'b1;
        end else if (r_state == S_SL_DONE && r_rdk == RK_APPEND) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_vcnt);
            ram_wdata = {r_in_y, r_in_x};
        end
    end

    pawk_ram #(.WIDTH(2*CW), .DEPTH(MAX_VERTICES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[CW-1:0];
    assign rd_y = ram_rdata[2*CW-1:CW];

    // shared multiplier
    logic [MA-1:0]     mul_a;
    logic [DIST_W-1:0] mul_b;
    logic [NW-1:0]     mul_p;
    logic [MA:0]       lerp_d;
    logic signed [MA:0] lerp_sd;

    assign lerp_d  = r_ylane ? mag_diff(r_cy, r_by) : mag_diff(r_cx, r_bx);
    assign lerp_sd = r_ylane ? (MA+1)'(r_by) - (MA+1)'(r_cy)
                             : (MA+1)'(r_bx) - (MA+1)'(r_cx);

    always_comb begin
        case (r_state)
            S_SL_MX: begin
                mul_a = r_dx;
                mul_b = r_dx[DIST_W-1:0];
            end
            S_SL_MY: begin
                mul_a = r_dy;
                mul_b = r_dy[DIST_W-1:0];
            end
            default: begin
                mul_a = lerp_d[MA-1:0];
                mul_b = r_len;
            end
        endcase
    end
    assign mul_p = NW'(mul_a) * NW'(mul_b);

    // segment length differences
    logic [MA:0] sl_dx, sl_dy;
    assign sl_dx = mag_diff(r_ax, r_bx);
    assign sl_dy = mag_diff(r_ay, r_by);

    // square root step: two radicand bits a cycle
    logic [RT_W+2:0] sq_t, sq_trial;
    logic            sq_ge;
    assign sq_t     = {r_rem, r_acc[SQ_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // restoring divide step
    logic [DIST_W:0] dv_t;
    logic            dv_ge;
    assign dv_t  = {r_drem, r_num[NW-1]};
    assign dv_ge = dv_t >= {1'b0, r_sl};

    logic signed [CW-1:0] lerp_c, lerp_q, lerp_r;
    assign lerp_c = r_ylane ? r_cy : r_cx;
    assign lerp_q = CW'(r_num);
    assign lerp_r = r_neg ? lerp_c - lerp_q : lerp_c + lerp_q;

    logic can_load;
    assign can_load = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcnt   <= '0;
            r_seg    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_dist   <= '0;
            r_end    <= 1'b0;
            r_plen   <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_elast  <= 1'b0;
            r_unwind <= 1'b0;
            r_ylane  <= 1'b0;
            r_rdk    <= RK_APPEND;
            r_raddr  <= '0;
            r_cnt    <= '0;
        end else begin
            // drop a taken word unless the emit state reloads the register
            if (r_ovalid && m_axis_tready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_in_x   <= in_x;
                        r_in_y   <= in_y;
                        r_len    <= in_dist;
                        r_unwind <= 1'b0;
                        r_elast  <= 1'b1;
                        if (new_path) begin
                            r_vcnt  <= VCW'(1);
                            r_seg   <= '0;
                            r_cx    <= in_x;
                            r_cy    <= in_y;
                            r_dist  <= '0;
                            r_end   <= 1'b0;
                            r_plen  <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            case (in_mode)
                                MODE_APPEND: begin
                                    if (r_vcnt < VCW'(MAX_VERTICES)) begin
                                        r_raddr <= AW'(r_vcnt - VCW'(1));
                                        r_rdk   <= RK_APPEND;
                                        r_state <= S_RDWAIT;
                                    end else begin
                                        r_state <= S_EMIT;
                                    end
                                end
                                MODE_SETPOS: begin
                                    r_seg  <= '0;
                                    r_dist <= '0;
                                    r_end  <= 1'b0;
                                    if (r_vcnt == '0) begin
                                        r_cx    <= '0;
                                        r_cy    <= '0;
                                        r_state <= S_WALK;
                                    end else begin
                                        r_raddr <= '0;
                                        r_rdk   <= RK_V0_SET;
                                        r_state <= S_RDWAIT;
                                    end
                                end
                                MODE_SKIP: begin
                                    r_state <= S_WALK;
                                end
                                MODE_UNWIND: begin
                                    r_unwind <= 1'b1;
                                    r_state  <= S_WALK;
                                end
                                default: begin
                                    r_state <= S_EMIT;
                                end
                            endcase
                        end
                    end
                end
                S_RDWAIT: begin
                    r_state <= S_RDUSE;
                end
                S_RDUSE: begin
                    case (r_rdk)
                        RK_APPEND: begin
                            r_ax    <= rd_x;
                            r_ay    <= rd_y;
                            r_bx    <= r_in_x;
                            r_by    <= r_in_y;
                            r_state <= S_SL_DIFF;
                        end
                        RK_V0_SET: begin
                            r_cx    <= rd_x;
                            r_cy    <= rd_y;
                            r_state <= S_WALK;
                        end
                        RK_V0_WALK: begin
                            r_cx    <= rd_x;
                            r_cy    <= rd_y;
                            r_state <= S_WSTART;
                        end
                        default: begin
                            r_ax    <= r_cx;
                            r_ay    <= r_cy;
                            r_bx    <= rd_x;
                            r_by    <= rd_y;
                            r_state <= S_SL_DIFF;
                        end
                    endcase
                end
                S_WALK: begin
                    if (VCW'(r_seg) + VCW'(1) >= r_vcnt) begin
                        // no segment ahead
                        if (r_unwind) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_end   <= 1'b1;
                            r_elast <= 1'b1;
                            r_state <= S_EMIT;
                        end
                    end else if (r_dist == '0) begin
                        r_raddr <= '0;
                        r_rdk   <= RK_V0_WALK;
                        r_state <= S_RDWAIT;
                    end else begin
                        r_state <= S_WSTART;
                    end
                end
                S_WSTART: begin
                    if (r_unwind) begin
                        r_elast <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_raddr <= r_seg + AW'(1);
                    r_rdk   <= RK_NEXT;
                    r_state <= S_RDWAIT;
                end
                S_SL_DIFF: begin
                    r_dx <= sl_dx[MA-1:0];
                    r_dy <= sl_dy[MA-1:0];
                    if (sl_dx > (MA+1)'(DIST_MAX) || sl_dy > (MA+1)'(DIST_MAX)) begin
                        r_sl    <= DIST_MAX;
                        r_state <= S_SL_DONE;
                    end else begin
                        r_state <= S_SL_MX;
                    end
                end
                S_SL_MX: begin
                    r_acc   <= SQ_W'(mul_p);
                    r_state <= S_SL_MY;
                end
                S_SL_MY: begin
                    r_acc   <= r_acc + SQ_W'(mul_p);
                    r_root  <= '0;
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(RT_W);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_acc <= {r_acc[SQ_W-3:0], 2'b00};
                    if (sq_ge) begin
                        r_rem  <= (RT_W+1)'(sq_t - sq_trial);
                        r_root <= {r_root[RT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= (RT_W+1)'(sq_t);
                        r_root <= {r_root[RT_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_SL_SAT;
                    end
                end
                S_SL_SAT: begin
                    r_sl    <= (r_root > RT_W'(DIST_MAX)) ? DIST_MAX : r_root[DIST_W-1:0];
                    r_state <= S_SL_DONE;
                end
                S_SL_DONE: begin
                    if (r_rdk == RK_APPEND) begin
                        r_plen  <= sat_add(r_plen, r_sl);
                        r_vcnt  <= r_vcnt + VCW'(1);
                        r_elast <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_len > r_sl) begin
                        // step past the whole segment
                        r_cx   <= r_bx;
                        r_cy   <= r_by;
                        r_dist <= sat_add(r_dist, r_sl);
                        r_len  <= r_len - r_sl;
                        r_seg  <= r_seg + AW'(1);
                        if (VCW'(r_seg) + VCW'(2) >= r_vcnt) begin
                            r_end   <= 1'b1;
                            r_elast <= 1'b1;
                            r_state <= S_EMIT;
                        end else if (r_unwind) begin
                            r_elast <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_dist  <= sat_add(r_dist, r_len);
                        r_elast <= 1'b1;
                        if (r_sl == '0) begin
                            // zero-length segment: land on its end vertex
                            r_cx    <= r_bx;
                            r_cy    <= r_by;
                            r_state <= S_EMIT;
                        end else begin
                            r_ylane <= 1'b0;
                            r_state <= S_LMUL;
                        end
                    end
                end
                S_LMUL: begin
                    r_num   <= mul_p;
                    r_neg   <= lerp_sd[MA];
                    r_drem  <= '0;
                    r_cnt   <= CNT_W'(NW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_ge) begin
                        r_drem <= DIST_W'(dv_t - {1'b0, r_sl});
                        r_num  <= {r_num[NW-2:0], 1'b1};
                    end else begin
                        r_drem <= DIST_W'(dv_t);
                        r_num  <= {r_num[NW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_LFIN;
                    end
                end
                S_LFIN: begin
                    if (r_ylane) begin
                        r_cy    <= lerp_r;
                        r_state <= S_EMIT;
                    end else begin
                        r_cx    <= lerp_r;
                        r_ylane <= 1'b1;
                        r_state <= S_LMUL;
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (can_load) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= r_elast;
                        r_odata  <= {2'b00, r_end, r_plen, r_dist, SEG_W'(r_seg),
                                     PT_W'(r_cy), PT_W'(r_cx)};
                        r_state  <= r_elast ? S_IDLE : S_NEXT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // the path never holds more vertices than the store
    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // the cursor segment stays on the path
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt == '0 || VCW'(r_seg) < r_vcnt)
        else $error("cursor segment beyond path");

    // a taken word blocks the input until its work is done
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

/* rtl/pawk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pawk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* verif/tb_top.sv */
// Self-checking bench for polyline_arc_length_walker: builds paths, moves the cursor,
// and checks every output word against an in-bench cursor/path predictor.
// Depends on pawk_pkg and the walker RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pawk_pkg::*;

    localparam int        NVERT    = 32;
    localparam longint    LEN_MAX  = 64'hFFFFFF;
    localparam int        DRAIN_CY = 1500;
    localparam int        HOLD_CY  = 400;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // one pending input word, or a control marker for the driver
    typedef struct {
        logic [2:0]  mode;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] dlen;
        bit          barrier;   // wait until every expected word has arrived
        bit          hold;      // ask the receiver for a long hold-off
        int          idle_pct;
        int          stall_pct;
    } t_word;

    typedef struct packed {
        logic [23:0] px;
        logic [23:0] py;
        logic [4:0]  seg;
        logic [23:0] trav;
        logic [23:0] total;
        logic        at_end;
        logic        last;
    } t_point;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_DW-1:0]   s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]  m_axis_tdata;
    logic               m_axis_tlast;

    polyline_arc_length_walker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    t_word  pending_words[$];
    t_point expected_points[$];
    int     mismatches = 0;
    int     sender_idle = 0;
    int     rx_stall = 0;
    bit     hold_toggle = 1'b0;
    int     gen_idle = 0;
    int     gen_stall = 0;

    // predictor copy of the path and cursor
    longint      path_x[NVERT];
    longint      path_y[NVERT];
    int          nverts = 0;
    int          cur_seg = 0;
    longint      cur_x = 0;
    longint      cur_y = 0;
    longint      cur_dist = 0;
    bit          cur_end = 1'b0;
    longint      total_len = 0;

    function automatic longint clamp_add(longint a, longint b);
        return (a + b > LEN_MAX) ? LEN_MAX : a + b;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint abs_l(longint d);
        return d < 0 ? -d : d;
    endfunction

    function automatic longint segment_length(longint ax, longint ay, longint bx, longint by);
        longint dx, dy, s;
        dx = abs_l(bx - ax);
        dy = abs_l(by - ay);
        if (dx > LEN_MAX || dy > LEN_MAX) return LEN_MAX;
        s = int_sqrt(dx * dx + dy * dy);
        return s > LEN_MAX ? LEN_MAX : s;
    endfunction

    // move a toward b by len out of seglen, truncating toward zero
    function automatic longint toward(longint a, longint b, longint len, longint seglen);
        longint d, m;
        if (seglen == 0) return b;
        d = b - a;
        m = abs_l(d) * len / seglen;
        return d < 0 ? a - m : a + m;
    endfunction

    task automatic push_point(longint px, longint py, bit last);
        t_point p;
        p.px = px[23:0];
        p.py = py[23:0];
        p.seg = cur_seg[4:0];
        p.trav = cur_dist[23:0];
        p.total = total_len[23:0];
        p.at_end = cur_end;
        p.last = last;
        expected_points.push_back(p);
    endtask

    task automatic start_path(longint x, longint y);
        path_x[0] = x;
        path_y[0] = y;
        nverts = 1;
        cur_seg = 0;
        cur_x = x;
        cur_y = y;
        cur_dist = 0;
        cur_end = 1'b0;
        total_len = 0;
    endtask

    // advance the cursor by len; in unwind form, emit each point reached
    task automatic walk_cursor(longint len, bit unwind);
        int     nxt;
        longint sl;
        int     first;
        first = expected_points.size();
        if (cur_seg + 1 >= nverts) begin
            if (!unwind) cur_end = 1'b1;
            return;
        end
        if (cur_dist == 0) begin
            cur_x = path_x[0];
            cur_y = path_y[0];
        end
        if (unwind) push_point(cur_x, cur_y, 1'b0);
        forever begin
            nxt = cur_seg + 1;
            if (nxt >= nverts) break;
            sl = segment_length(cur_x, cur_y, path_x[nxt], path_y[nxt]);
            if (len > sl) begin
                cur_x = path_x[nxt];
                cur_y = path_y[nxt];
                cur_dist = clamp_add(cur_dist, sl);
                len -= sl;
                cur_seg = nxt;
                if (nxt + 1 >= nverts) begin
                    cur_end = 1'b1;
                    if (unwind) push_point(cur_x, cur_y, 1'b0);
                    break;
                end
                if (unwind) push_point(cur_x, cur_y, 1'b0);
            end else begin
                cur_dist = clamp_add(cur_dist, len);
                cur_x = toward(cur_x, path_x[nxt], len, sl);
                cur_y = toward(cur_y, path_y[nxt], len, sl);
                if (unwind) push_point(cur_x, cur_y, 1'b0);
                break;
            end
        end
        if (unwind && expected_points.size() > first)
            expected_points[expected_points.size()-1].last = 1'b1;
    endtask

    // work out the words one accepted input causes
    task automatic predict_word(t_word w);
        longint x, y, d;
        x = longint'(signed'(w.vx));
        y = longint'(signed'(w.vy));
        d = longint'(w.dlen);
        case (w.mode)
            MODE_NEW: start_path(x, y);
            MODE_APPEND: begin
                if (nverts == 0) begin
                    start_path(x, y);
                end else if (nverts < NVERT) begin
                    total_len = clamp_add(total_len,
                        segment_length(path_x[nverts-1], path_y[nverts-1], x, y));
                    path_x[nverts] = x;
                    path_y[nverts] = y;
                    nverts++;
                end
            end
            MODE_SETPOS: begin
                cur_seg = 0;
                cur_dist = 0;
                cur_x = nverts != 0 ? path_x[0] : 0;
                cur_y = nverts != 0 ? path_y[0] : 0;
                cur_end = 1'b0;
                walk_cursor(d, 1'b0);
            end
            MODE_SKIP: walk_cursor(d, 1'b0);
            MODE_UNWIND: begin
                walk_cursor(d, 1'b1);
                return;
            end
            default: ;
        endcase
        push_point(cur_x, cur_y, 1'b1);
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic add_word(logic [2:0] mode, logic [23:0] x, logic [23:0] y, logic [23:0] d);
        t_word w;
        w = '{mode, x, y, d, 1'b0, 1'b0, gen_idle, gen_stall};
        pending_words.push_back(w);
    endtask

    task automatic add_marker(bit barrier, bit hold);
        t_word w;
        w = '{MODE_NEW, 24'd0, 24'd0, 24'd0, barrier, hold, gen_idle, gen_stall};
        pending_words.push_back(w);
    endtask

    // coordinates: mostly a small box so walks stay inside the path
    function automatic logic [23:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 75) return 24'($signed($urandom_range(8192)) - 4096);
        if (r < 85) return 24'($urandom);
        if (r < 90) return 24'h800000;
        if (r < 95) return 24'h7FFFFF;
        return 24'($signed($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic [23:0] pick_dist();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 24'd0;
        if (r < 70) return 24'($urandom_range(12000));
        if (r < 85) return 24'($urandom_range(60000));
        if (r < 93) return 24'($urandom);
        return 24'hFFFFFF;
    endfunction

    // one well-formed path followed by some cursor moves
    task automatic add_path_run();
        int nv, nm, r;
        logic [2:0] mv;
        add_word(MODE_NEW, pick_coord(), pick_coord(), 24'($urandom));
        r = $urandom_range(99);
        nv = r < 85 ? $urandom_range(1, 6) : (r < 95 ? $urandom_range(7, 20) : $urandom_range(29, 34));
        for (int i = 0; i < nv; i++)
            add_word(MODE_APPEND, pick_coord(), pick_coord(), 24'($urandom));
        nm = $urandom_range(1, 5);
        for (int i = 0; i < nm; i++) begin
            r = $urandom_range(2);
            mv = r == 0 ? MODE_SETPOS : (r == 1 ? MODE_SKIP : MODE_UNWIND);
            add_word(mv, 24'($urandom), 24'($urandom), pick_dist());
        end
    endtask

    task automatic add_noise();
        add_word(3'($urandom_range(MODE_SPARE_HI)), 24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // ---------------- stimulus ----------------
    initial begin
        // directed: empty path cases, then corner cases on small paths
        add_word(MODE_SETPOS, 24'd0, 24'd0, 24'd100);
        add_word(MODE_SKIP, 24'd0, 24'd0, 24'hFFFFFF);
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'd50);
        add_word(MODE_SPARE_LO, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_word(MODE_APPEND, 24'd256, 24'd512, 24'd0);          // acts as new path
        add_word(MODE_SKIP, 24'd0, 24'd0, 24'd10);                // no segment ahead
        add_word(MODE_APPEND, 24'd256, 24'd512, 24'd0);          // zero-length segment
        add_word(MODE_APPEND, 24'd1280, 24'd512, 24'd0);
        add_word(MODE_SKIP, 24'd0, 24'd0, 24'd0);                 // skip from distance zero
        add_word(MODE_SKIP, 24'd0, 24'd0, 24'd300);
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'd1024);            // runs past the end
        add_word(MODE_SETPOS, 24'd0, 24'd0, 24'd1023);
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'd2);               // runs out
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'd2);               // nothing ahead
        add_word(MODE_NEW, 24'h800000, 24'h800000, 24'd0);
        add_word(MODE_APPEND, 24'h7FFFFF, 24'h7FFFFF, 24'd0);     // saturated length
        add_word(MODE_APPEND, 24'h7FFFFF, 24'h800000, 24'd0);
        add_word(MODE_SETPOS, 24'd0, 24'd0, 24'hFFFFFF);
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'hFFFFFF);
        add_word(MODE_SPARE_HI, 24'd0, 24'd0, 24'd0);
        // full path plus appends that are dropped
        add_word(MODE_NEW, 24'd0, 24'd0, 24'd0);
        for (int i = 1; i < 34; i++)
            add_word(MODE_APPEND, 24'(i * 64), 24'((i % 2) * 48), 24'd0);
        add_word(MODE_UNWIND, 24'd0, 24'd0, 24'hFFFFFF);          // longest emit burst
        add_marker(1'b1, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            gen_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 24) : 0;
            gen_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 24) : 0;
            if (ph == 1) gen_stall = 0;
            if (ph == 0) add_marker(1'b0, 1'b1);   // long receiver hold-off
            for (int k = 0; k < 11; k++) begin
                if ($urandom_range(99) < 80) add_path_run();
                else add_noise();
            end
            add_marker(1'b1, 1'b0);                // sender pause until drained
        end
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin : drive
        logic  go;
        t_word w;
        go = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(pending_words[0]);
                rx_stall = pending_words[0].stall_pct;
                void'(pending_words.pop_front());
                go = 1'b0;
            end
            if (!go && pending_words.size() != 0) begin
                w = pending_words[0];
                sender_idle = w.idle_pct;
                if (w.barrier) begin
                    // hold off until every expected word has come back
                    if (expected_points.size() == 0) void'(pending_words.pop_front());
                end else if (w.hold) begin
                    hold_toggle <= ~hold_toggle;
                    void'(pending_words.pop_front());
                end else if ($urandom_range(99) >= sender_idle) begin
                    s_axis_tdata <= {5'd0, w.dlen, w.vy, w.vx, w.mode};
                    go = 1'b1;
                end
            end
            s_axis_tvalid <= go;
        end
    end

    // ---------------- receiver ----------------
    always @(posedge i_clk) begin : receive
        int hold_left;
        bit seen_toggle;
        if (!i_rst_n) begin
            hold_left = 0;
            seen_toggle = hold_toggle;
            m_axis_tready <= 1'b0;
        end else if (seen_toggle != hold_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = HOLD_CY;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= rx_stall;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : monitor
        t_point got, exp_p;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.px = m_axis_tdata[23:0];
            got.py = m_axis_tdata[47:24];
            got.seg = m_axis_tdata[52:48];
            got.trav = m_axis_tdata[76:53];
            got.total = m_axis_tdata[100:77];
            got.at_end = m_axis_tdata[101];
            got.last = m_axis_tlast;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pt=(%h,%h) seg=%0d trav=%h total=%h end=%b last=%b",
                             got.px, got.py, got.seg, got.trav, got.total, got.at_end, got.last);
            end else begin
                exp_p = expected_points.pop_front();
                if (got !== exp_p) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: pt=(%h,%h) seg=%0d trav=%h total=%h end=%b last=%b",
                                 exp_p.px, exp_p.py, exp_p.seg, exp_p.trav, exp_p.total,
                                 exp_p.at_end, exp_p.last);
                        $display("         got: pt=(%h,%h) seg=%0d trav=%h total=%h end=%b last=%b",
                                 got.px, got.py, got.seg, got.trav, got.total, got.at_end,
                                 got.last);
                    end
                end
            end
        end
    end

    // ---------------- reset and end of run ----------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
